### hw/rtl/npas_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the node pool allocator with mark and sweep.
package npas_pkg;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_ALLOC = 2'd0;
  localparam func_t FUNC_MARK  = 2'd1;
  localparam func_t FUNC_SWEEP = 2'd2;

  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  localparam logic [10:0] FREED_MAX = 11'h7FF;

  typedef struct packed {
    func_t      func;
    logic [9:0] node_index;
  } npas_req_t;

  typedef struct packed {
    logic        status;
    logic [9:0]  granted_index;
    logic [10:0] freed_count;
  } npas_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep;
    logic hold;
    logic load_now;
    logic load_held;
  } npas_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sweep;
    logic sweep_done;
    logic rsp_valid;
  } npas_sts_t;

endpackage

### hw/rtl/npas_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the node pool allocator.
module npas_ctrl
  import npas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  logic      rsp_stall,
  input  npas_sts_t sts,
  output npas_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_HOLD  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_free;

  assign rsp_free  = !sts.rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_sweep) begin
          state_next = S_SWEEP;
        end else if (rsp_free) begin
          cmd.load_now = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.hold   = 1'b1;
          state_next = S_HOLD;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          if (rsp_free) begin
            cmd.load_now = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.hold   = 1'b1;
            state_next = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (rsp_free) begin
          cmd.load_held = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/npas_dp.sv
`timescale 1ns / 1ps
// Datapath of the node pool allocator: node memories, free list, bump pointer, sweep scan.
module npas_dp
  import npas_pkg::*;
#(
  parameter int POOL_NODES = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  npas_req_t req,
  input  logic      rsp_stall,
  output logic      rsp_valid,
  output npas_rsp_t rsp,
  input  npas_cmd_t cmd,
  output npas_sts_t sts
);

  localparam int IDX_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int PTR_W = IDX_W + 1;
  localparam int CMP_W = IDX_W + 11;
  localparam logic [PTR_W-1:0] POOL_END = PTR_W'(POOL_NODES);

  // Per-node memories.
  logic             alloc_mem [POOL_NODES];
  logic             mark_mem  [POOL_NODES];
  logic [IDX_W-1:0] link_mem  [POOL_NODES];

  logic [IDX_W-1:0] link_rd;
  logic             alloc_rd;
  logic             mark_rd;

  // Captured transaction.
  func_t      op;
  logic [9:0] idx;

  // Pool state.
  logic [IDX_W-1:0] head;
  logic             empty;
  logic [PTR_W-1:0] bump;

  // Sweep scan.
  logic [PTR_W-1:0] scan_addr;
  logic             proc_valid;
  logic [IDX_W-1:0] proc_index;
  logic [10:0]      freed;

  npas_rsp_t res_held;
  npas_rsp_t res_next;

  logic             from_list;
  logic             from_bump;
  logic             exhausted;
  logic [IDX_W-1:0] node;
  logic             mark_ok;
  logic             issue;

  logic             a_we;
  logic [IDX_W-1:0] a_wa;
  logic             a_wd;
  logic             m_we;
  logic [IDX_W-1:0] m_wa;
  logic             m_wd;
  logic             l_we;
  logic [IDX_W-1:0] l_wa;
  logic [IDX_W-1:0] l_wd;

  assign from_list = !empty;
  assign from_bump = empty && (bump != POOL_END);
  assign exhausted = !from_list && !from_bump;
  assign node      = from_list ? head : bump[IDX_W-1:0];
  // Nodes at or above the bump pointer get their mark cleared when handed out,
  // so a mark there has no visible effect and is dropped.
  assign mark_ok   = CMP_W'(idx) < CMP_W'(bump);
  assign issue     = cmd.sweep && (scan_addr < bump);

  assign sts.is_sweep   = (op == FUNC_SWEEP);
  assign sts.sweep_done = !proc_valid && (scan_addr >= bump);
  assign sts.rsp_valid  = rsp_valid;

  always_comb begin
    res_next = '0;
    case (op)
      FUNC_ALLOC: begin
        if (exhausted) begin
          res_next.status = STATUS_EXHAUSTED;
        end else begin
          res_next.status        = STATUS_DONE;
          res_next.granted_index = 10'(node);
        end
      end
      FUNC_SWEEP: begin
        res_next.freed_count = freed;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_comb begin
    a_we = 1'b0;
    a_wa = node;
    a_wd = 1'b0;
    m_we = 1'b0;
    m_wa = node;
    m_wd = 1'b0;
    l_we = 1'b0;
    l_wa = proc_index;
    l_wd = empty ? proc_index : head;
    if (cmd.exec && (op == FUNC_ALLOC) && !exhausted) begin
      a_we = 1'b1;
      a_wd = 1'b1;
      m_we = 1'b1;
    end else if (cmd.exec && (op == FUNC_MARK) && mark_ok) begin
      m_we = 1'b1;
      m_wa = IDX_W'(idx);
      m_wd = 1'b1;
    end else if (cmd.sweep && proc_valid) begin
      a_wa = proc_index;
      m_wa = proc_index;
      if (alloc_rd && mark_rd) begin
        m_we = 1'b1;
      end
      if (alloc_rd && !mark_rd) begin
        a_we = 1'b1;
      end
      if (!(alloc_rd && mark_rd)) begin
        l_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      alloc_mem[a_wa] <= a_wd;
    end
    if (m_we) begin
      mark_mem[m_wa] <= m_wd;
    end
    if (l_we) begin
      link_mem[l_wa] <= l_wd;
    end
    link_rd <= link_mem[head];
    if (issue) begin
      alloc_rd <= alloc_mem[scan_addr[IDX_W-1:0]];
      mark_rd  <= mark_mem[scan_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= req.func;
      idx <= req.node_index;
    end
    if (cmd.hold) begin
      res_held <= res_next;
    end
    if (cmd.load_now) begin
      rsp <= res_next;
    end else if (cmd.load_held) begin
      rsp <= res_held;
    end
    if (issue) begin
      proc_index <= scan_addr[IDX_W-1:0];
    end
    if (cmd.exec && (op == FUNC_SWEEP)) begin
      freed     <= '0;
      scan_addr <= '0;
    end else begin
      if (issue) begin
        scan_addr <= scan_addr + PTR_W'(1);
      end
      if (cmd.sweep && proc_valid && alloc_rd && !mark_rd && (freed != FREED_MAX)) begin
        freed <= freed + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      empty      <= 1'b1;
      bump       <= '0;
      proc_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      proc_valid <= issue;
      if (cmd.exec && (op == FUNC_ALLOC)) begin
        if (from_list) begin
          if (link_rd == head) begin
            empty <= 1'b1;
            head  <= '0;
          end else begin
            head <= link_rd;
          end
        end else if (from_bump) begin
          bump <= bump + PTR_W'(1);
        end
      end else if (cmd.exec && (op == FUNC_SWEEP)) begin
        empty <= 1'b1;
        head  <= '0;
      end else if (cmd.sweep && proc_valid && !(alloc_rd && mark_rd)) begin
        head  <= proc_index;
        empty <= 1'b0;
      end
      if (cmd.load_now || cmd.load_held) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/node_pool_allocator_sweep_core.sv
`timescale 1ns / 1ps
// Top level of the node pool allocator with free list and mark and sweep collection.
//
// This block manages a pool of POOL_NODES nodes. An allocate transaction pops
// the head of the free list, or hands out the bump pointer when the list is
// empty, and returns the granted node; with both exhausted it returns status 1.
// A mark transaction sets the mark bit of one node. A sweep transaction walks
// every node below the bump pointer in index order, clears the mark of marked
// allocated nodes, frees unmarked ones, rebuilds the free list from all free
// nodes (head is the highest free index) and returns the freed count, which
// saturates at 2047. Allocate and mark first capture the transaction while the
// link memory is read at the free-list head, then update the pool. A sweep
// runs a scan that reads one node per cycle from the node memories and
// updates it in the following cycle. One transaction is worked on at a time;
// a finished result waits in the output register while the next transaction
// is accepted. No clearing pass follows reset: nodes at or above the bump
// pointer are never read before the allocate that hands them out writes them.
module node_pool_allocator_sweep_core
  import npas_pkg::*;
#(
  parameter int POOL_NODES = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  npas_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output npas_rsp_t rsp
);

  npas_cmd_t cmd;
  npas_sts_t sts;

  // The controller sequences capture, execute, sweep scan and result hand-off.
  npas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the node memories, the free list and the output register.
  npas_dp #(
    .POOL_NODES (POOL_NODES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### tb/sv/node_pool_allocator_sweep_core_tb.sv
`timescale 1ns / 1ps
// Testbench for the node pool allocator: directed and random traffic checked against a pool model.
module node_pool_allocator_sweep_core_tb;
  import npas_pkg::*;

  localparam int POOL_NODES = 1024;
  // The generous cycle budget covers the full-pool sweeps, plus every other transaction
  // waiting out the longest idle and stall bursts, several times over.
  localparam int CYCLE_LIMIT = 600000;
  // The one function code the block does not define; it must change nothing.
  localparam func_t FUNC_UNUSED = 2'd3;

  // Holds a private copy of the pool state and the responses it still owes.
  class pool_scoreboard;
    logic       node_used   [POOL_NODES];
    logic       node_marked [POOL_NODES];
    logic [9:0] node_link   [POOL_NODES];
    logic [9:0] list_head;
    logic       list_empty;
    int         bump_ptr;
    int         exhausted_seen;
    npas_rsp_t  owed_rsp [$];

    function new();
      foreach (node_used[i]) begin
        node_used[i]   = 1'b0;
        node_marked[i] = 1'b0;
        node_link[i]   = '0;
      end
      list_head      = '0;
      list_empty     = 1'b1;
      bump_ptr       = 0;
      exhausted_seen = 0;
    endfunction

    // Applies one transaction to the pool copy and returns the response it must produce.
    function npas_rsp_t predict_pool_op(npas_req_t r);
      npas_rsp_t res;
      int        node;
      int        freed;
      res = '0;
      case (r.func)
        FUNC_ALLOC: begin
          node = -1;
          if (!list_empty) begin
            node = int'(list_head);
            // The tail of the free list links to itself.
            if (int'(node_link[node]) == node) begin
              list_empty = 1'b1;
              list_head  = '0;
            end else begin
              list_head = node_link[node];
            end
          end else if (bump_ptr < POOL_NODES) begin
            node = bump_ptr;
            bump_ptr++;
          end
          if (node < 0) begin
            res.status = STATUS_EXHAUSTED;
            exhausted_seen++;
          end else begin
            node_used[node]   = 1'b1;
            node_marked[node] = 1'b0;
            res.status        = STATUS_DONE;
            res.granted_index = 10'(node);
          end
        end
        FUNC_MARK: begin
          if (int'(r.node_index) < POOL_NODES) node_marked[r.node_index] = 1'b1;
        end
        FUNC_SWEEP: begin
          freed      = 0;
          list_empty = 1'b1;
          list_head  = '0;
          for (int i = 0; i < bump_ptr; i++) begin
            if (node_used[i]) begin
              if (node_marked[i]) begin
                node_marked[i] = 1'b0;
              end else begin
                node_used[i] = 1'b0;
                if (freed < int'(FREED_MAX)) freed++;
              end
            end
            if (!node_used[i]) begin
              node_link[i] = list_empty ? 10'(i) : list_head;
              list_head    = 10'(i);
              list_empty   = 1'b0;
            end
          end
          res.freed_count = 11'(freed);
        end
        default: begin
        end
      endcase
      return res;
    endfunction

    function void note_request(npas_req_t r);
      owed_rsp.push_back(predict_pool_op(r));
    endfunction

    // Returns an empty string on a match, else a description of what differed.
    function string check_response(npas_rsp_t got);
      npas_rsp_t want;
      string     diff;
      if (owed_rsp.size() == 0) return $sformatf("unexpected response %h", got);
      want = owed_rsp.pop_front();
      diff = "";
      if (got.status !== want.status)
        diff = {diff, $sformatf(" status %b/%b", got.status, want.status)};
      if (got.granted_index !== want.granted_index)
        diff = {diff, $sformatf(" granted_index %0d/%0d", got.granted_index, want.granted_index)};
      if (got.freed_count !== want.freed_count)
        diff = {diff, $sformatf(" freed_count %0d/%0d", got.freed_count, want.freed_count)};
      if (diff != "") return {"response field got/want:", diff};
      return "";
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  npas_req_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  npas_rsp_t rsp;

  pool_scoreboard sb = new();

  int    error_count = 0;
  int    cycle_count = 0;
  int    stall_left  = 0;
  bit    idle_on     = 1'b1;
  string rsp_msg;

  node_pool_allocator_sweep_core #(
    .POOL_NODES(POOL_NODES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Offers one request transaction, possibly after a short idle burst, and holds it until the
  // block accepts it. All signals are sampled right after the edge, so they hold the values
  // that the edge itself saw. The predictor is updated here, at acceptance, so the next
  // request can be chosen from the up-to-date pool state.
  task automatic send_request(input npas_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  task automatic send_op(input func_t f, input logic [9:0] idx);
    npas_req_t r;
    r.func       = f;
    r.node_index = idx;
    send_request(r);
  endtask

  // Draws one random request with the given percentages for allocate, mark and sweep; the rest
  // of the range goes to the unused function code. Most marks land below the bump pointer, where
  // they can protect a live node from the next sweep.
  function automatic npas_req_t random_request(int alloc_pct, int mark_pct, int sweep_pct);
    npas_req_t r;
    int        pick;
    r.node_index = 10'($urandom);
    pick         = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      r.func = FUNC_ALLOC;
    end else if (pick < alloc_pct + mark_pct) begin
      r.func = FUNC_MARK;
      if (sb.bump_ptr > 0 && $urandom_range(0, 4) != 0)
        r.node_index = 10'($urandom_range(0, sb.bump_ptr - 1));
    end else if (pick < alloc_pct + mark_pct + sweep_pct) begin
      r.func = FUNC_SWEEP;
    end else begin
      r.func = FUNC_UNUSED;
    end
    return r;
  endfunction

  // Sends random requests until the given number of meaningful ones has gone out; the unused
  // function code does not count, since the block only ignores it.
  task automatic run_random(input int items, input int alloc_pct, input int mark_pct,
                            input int sweep_pct);
    npas_req_t r;
    int        sent;
    sent = 0;
    while (sent < items) begin
      r = random_request(alloc_pct, mark_pct, sweep_pct);
      send_request(r);
      if (r.func != FUNC_UNUSED) sent++;
    end
  endtask

  // Checks every response transaction and drives the response stall in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_msg = sb.check_response(rsp);
        if (rsp_msg != "") report_mismatch(rsp_msg);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // A hang anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("node_pool_allocator_sweep_core_tb: errors");
      $finish;
    end
  end

  initial begin
    int start_exhausted;
    int guard;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A sweep of an empty pool frees nothing, and the unused function code
    // returns zeros.
    send_op(FUNC_SWEEP, 10'h000);
    send_op(FUNC_UNUSED, 10'h3FF);
    // Marking a node at or above the bump pointer changes nothing; the allocate that hands it out clears its mark.
    send_op(FUNC_MARK, 10'h000);
    send_op(FUNC_ALLOC, 10'h3FF);
    send_op(FUNC_ALLOC, 10'h000);
    send_op(FUNC_ALLOC, 10'h2AA);
    send_op(FUNC_ALLOC, 10'h155);
    // Protect nodes 1 and 3; the marks at the far end of the pool fall on free nodes.
    send_op(FUNC_MARK, 10'h001);
    send_op(FUNC_MARK, 10'h003);
    send_op(FUNC_MARK, 10'h3FF);
    send_op(FUNC_MARK, 10'h155);
    send_op(FUNC_MARK, 10'h2AA);
    // This sweep frees nodes 0 and 2, so the list is 2 then 0, and 0 links to itself.
    send_op(FUNC_SWEEP, 10'h3FF);
    send_op(FUNC_ALLOC, 10'h000);
    // Popping the tail of the list empties it, so the next allocate takes the bump pointer.
    send_op(FUNC_ALLOC, 10'h000);
    send_op(FUNC_ALLOC, 10'h000);
    // The marks were spent by the last sweep, so this one frees every node.
    send_op(FUNC_SWEEP, 10'h000);
    send_op(FUNC_MARK, 10'h3FF);
    send_op(FUNC_UNUSED, 10'h000);
    send_op(FUNC_ALLOC, 10'h3FF);
    send_op(FUNC_MARK, 10'h000);
    send_op(FUNC_SWEEP, 10'h155);

    // A general mix with frequent sweeps, while the pool is still small.
    run_random(500, 52, 35, 10);

    // Fill the pool with allocates and a few marks until the bump pointer reaches the end and
    // allocates start to report exhaustion.
    start_exhausted = sb.exhausted_seen;
    guard           = 0;
    while (sb.exhausted_seen - start_exhausted < 16 && guard < 1500) begin
      send_request(random_request(88, 10, 0));
      guard++;
    end

    // A full pool: marks, sweeps over every node, and allocates that drain the rebuilt list.
    run_random(150, 25, 60, 10);

    // The last stretch runs with neither side idling.
    idle_on = 1'b0;
    run_random(200, 52, 35, 8);
    @(posedge clk);
    req_valid <= 1'b0;

    while (sb.owed_rsp.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (error_count == 0) begin
      $display("node_pool_allocator_sweep_core_tb: clean");
    end else begin
      $display("node_pool_allocator_sweep_core_tb: errors");
    end
    $finish;
  end

endmodule
